[rtl/tlbr_pkg.sv]
package tlbr_pkg;

    localparam int SLOT_W     = 4;
    localparam int EIU_W      = 5;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [EIU_W-1:0] EIU_RESET  = 5'd4;
    localparam logic             OP_FILL    = 1'b1;
    localparam logic             POLICY_LRU = 1'b1;

    typedef enum logic [0:0] {
        REG_POLICY  = 1'b0,
        REG_ENTRIES = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC,
        ST_HUPD,
        ST_FILL,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic cmp;
        logic enc;
        logic hit_upd;
        logic append;
        logic scan_first;
        logic scan_step;
        logic replace;
        logic out_load;
    } tlbr_cmd_t;

    typedef struct packed {
        logic in_op;
        logic room;
        logic scan_done;
        logic out_free;
    } tlbr_sts_t;

    typedef struct packed {
        logic             policy;
        logic [EIU_W-1:0] entries_in_use;
    } tlbr_cfg_t;

endpackage

[rtl/tlbr_req_if.sv]
interface tlbr_req_if #(
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;

    modport source (output valid, op, page, frame, input ready);
    modport sink   (input valid, op, page, frame, output ready);
endinterface

[rtl/tlbr_rsp_if.sv]
interface tlbr_rsp_if #(
    parameter int FRAME_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [FRAME_BITS-1:0]         frame_out;
    logic [tlbr_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, hit, frame_out, slot, input ready);
    modport sink   (input valid, hit, frame_out, slot, output ready);
endinterface

[rtl/tlbr_ram.sv]
module tlbr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/tlbr_cfg_regs.sv]
module tlbr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlbr_pkg::PADDR_W-1:0]       paddr,
    input  logic [tlbr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tlbr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output tlbr_pkg::tlbr_cfg_t                cfg
);
    import tlbr_pkg::*;

    logic             policy_reg;
    logic [EIU_W-1:0] eiu_reg;
    reg_idx_t         reg_idx;
    logic             wr_en;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            eiu_reg    <= EIU_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_POLICY:  policy_reg <= pwdata[0];
                REG_ENTRIES: eiu_reg    <= pwdata[EIU_W-1:0];
                default:     policy_reg <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POLICY:  prdata = CFG_DATA_W'(policy_reg);
            REG_ENTRIES: prdata = CFG_DATA_W'(eiu_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.policy         = policy_reg;
    assign cfg.entries_in_use = eiu_reg;
endmodule

[rtl/tlbr_ctrl.sv]
module tlbr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tlbr_pkg::tlbr_sts_t  sts,
    output tlbr_pkg::tlbr_cmd_t  cmd
);
    import tlbr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (sts.in_op == OP_FILL) ? ST_FILL : ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = ST_HUPD;
            end
            ST_HUPD:
            begin
                cmd.hit_upd = 1'b1;
                state_next  = ST_DONE;
            end
            ST_FILL:
            begin
                if (sts.room)
                begin
                    cmd.append = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_first = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.replace = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/tlbr_datapath.sv]
module tlbr_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int PAGE_BITS   = 20,
    parameter int FRAME_BITS  = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlbr_pkg::tlbr_cfg_t           cfg,
    input  tlbr_pkg::tlbr_cmd_t           cmd,
    output tlbr_pkg::tlbr_sts_t           sts,
    input  logic                          in_op,
    input  logic [PAGE_BITS-1:0]          in_page,
    input  logic [FRAME_BITS-1:0]         in_frame,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic [FRAME_BITS-1:0]         out_frame,
    output logic [tlbr_pkg::SLOT_W-1:0]   out_slot
);
    import tlbr_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] AGE_TOP = IDX_W'(MAX_ENTRIES - 1);

    logic [PAGE_BITS-1:0]  page_in_reg;
    logic [FRAME_BITS-1:0] frame_in_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [PAGE_BITS-1:0]  page_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]      age_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]      age_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_reg;
    logic [MAX_ENTRIES-1:0] match_next;
    logic [MAX_ENTRIES-1:0] in_use;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [CNT_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [IDX_W-1:0]      best_age_reg;
    logic                  res_hit_reg;
    logic [FRAME_BITS-1:0] res_frame_reg;
    logic [IDX_W-1:0]      res_slot_reg;
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [FRAME_BITS-1:0] out_frame_reg;
    logic [SLOT_W-1:0]     out_slot_reg;

    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      cnt_m1;
    logic                  lru;
    logic                  enc_hit;
    logic [IDX_W-1:0]      enc_idx;
    logic [IDX_W-1:0]      hit_age;
    logic [IDX_W-1:0]      scan_age;
    logic                  scan_better;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_slot;
    logic [FRAME_BITS-1:0] frame_rd;

    function automatic logic [IDX_W-1:0] age_up(input logic [IDX_W-1:0] a);
        return (a >= AGE_TOP) ? AGE_TOP : a + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] age_down(input logic [IDX_W-1:0] a);
        return (a == '0) ? '0 : a - IDX_W'(1);
    endfunction

    always_comb
    begin
        if (cfg.entries_in_use == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (int'(cfg.entries_in_use) > MAX_ENTRIES)
        begin
            limit = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            limit = CNT_W'(cfg.entries_in_use);
        end
    end

    assign lru    = (cfg.policy == POLICY_LRU);
    assign cnt_m1 = count_reg - CNT_W'(1);

    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            in_use[k]     = CNT_W'(k) < count_reg;
            match_next[k] = in_use[k] && (page_reg[k] == page_in_reg);
        end
    end

    always_comb
    begin
        enc_hit = 1'b0;
        enc_idx = '0;
        for (int k = MAX_ENTRIES - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                enc_hit = 1'b1;
                enc_idx = IDX_W'(k);
            end
        end
    end

    assign hit_age     = age_reg[hit_idx_reg];
    assign scan_age    = age_reg[scan_idx_reg[IDX_W-1:0]];
    assign scan_better = lru ? (scan_age > best_age_reg) : (scan_age < best_age_reg);
    assign wr_en       = cmd.append || cmd.replace;
    assign wr_slot     = cmd.append ? count_reg[IDX_W-1:0] : best_idx_reg;
    assign count_next  = cmd.append ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            age_next[k] = age_reg[k];
            if (cmd.hit_upd && hit_reg && lru)
            begin
                if (IDX_W'(k) == hit_idx_reg)
                begin
                    age_next[k] = '0;
                end
                else if (in_use[k] && (age_reg[k] < hit_age))
                begin
                    age_next[k] = age_up(age_reg[k]);
                end
            end
            else if (cmd.append)
            begin
                if (lru && in_use[k])
                begin
                    age_next[k] = age_up(age_reg[k]);
                end
                if (CNT_W'(k) == count_reg)
                begin
                    age_next[k] = lru ? '0 : count_reg[IDX_W-1:0];
                end
            end
            else if (cmd.replace)
            begin
                if (IDX_W'(k) == best_idx_reg)
                begin
                    age_next[k] = lru ? '0 : cnt_m1[IDX_W-1:0];
                end
                else if (in_use[k])
                begin
                    age_next[k] = lru ? age_up(age_reg[k]) : age_down(age_reg[k]);
                end
            end
        end
    end

    tlbr_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_slot),
        .wdata (frame_in_reg),
        .raddr (enc_idx),
        .rdata (frame_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.scan_first)
            begin
                scan_idx_reg <= CNT_W'(1);
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg <= age_next;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            if (wr_en && (IDX_W'(k) == wr_slot))
            begin
                page_reg[k] <= page_in_reg;
            end
        end
        if (cmd.load_in)
        begin
            page_in_reg  <= in_page;
            frame_in_reg <= in_frame;
        end
        if (cmd.cmp)
        begin
            match_reg <= match_next;
        end
        if (cmd.enc)
        begin
            hit_reg     <= enc_hit;
            hit_idx_reg <= enc_idx;
        end
        if (cmd.scan_first)
        begin
            best_idx_reg <= '0;
            best_age_reg <= age_reg[0];
        end
        else if (cmd.scan_step && scan_better)
        begin
            best_idx_reg <= scan_idx_reg[IDX_W-1:0];
            best_age_reg <= scan_age;
        end
        if (cmd.hit_upd)
        begin
            res_hit_reg   <= hit_reg;
            res_frame_reg <= hit_reg ? frame_rd : '0;
            res_slot_reg  <= hit_reg ? hit_idx_reg : '0;
        end
        else if (wr_en)
        begin
            res_hit_reg   <= 1'b0;
            res_frame_reg <= '0;
            res_slot_reg  <= wr_slot;
        end
        if (cmd.out_load)
        begin
            out_hit_reg   <= res_hit_reg;
            out_frame_reg <= res_frame_reg;
            out_slot_reg  <= SLOT_W'(res_slot_reg);
        end
    end

    assign sts.in_op     = in_op;
    assign sts.room      = count_reg < limit;
    assign sts.scan_done = scan_idx_reg >= count_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_frame = out_frame_reg;
    assign out_slot  = out_slot_reg;
endmodule

[rtl/tlb_fifo_lru_replacement.sv]
// Channel  Dir  Payload                          Handshake
// req      in   op, page, frame                  valid / ready
// rsp      out  hit, frame_out, slot             valid / ready
// apb      in   policy, entries_in_use           psel / penable / pready
//
// A lookup passes from acceptance to the next ready through compare, priority
// encode with the frame RAM read, the recency update, and the result load.
// A fill that appends writes its entry directly; a fill that replaces first
// walks the filled entries in a victim scan to find the slot to overwrite.
// Reset clears the fill count, so no entry is valid after reset.
// A result waits in the output register while the next word is accepted; a
// stalled output holds the following word in its final state until it drains.
module tlb_fifo_lru_replacement #(
    parameter int MAX_ENTRIES = 16,
    parameter int PAGE_BITS   = 20,
    parameter int FRAME_BITS  = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tlbr_req_if.sink                           req,
    tlbr_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlbr_pkg::PADDR_W-1:0]       paddr,
    input  logic [tlbr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tlbr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import tlbr_pkg::*;

    tlbr_cfg_t cfg;
    tlbr_cmd_t cmd;
    tlbr_sts_t sts;

    tlbr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlbr_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (req.op),
        .in_page   (req.page),
        .in_frame  (req.frame),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_hit   (rsp.hit),
        .out_frame (rsp.frame_out),
        .out_slot  (rsp.slot)
    );
endmodule

[rtl/tlbr_checker.sv]
module tlbr_checker #(
    parameter int FRAME_BITS = 20
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic                             rsp_hit,
    input logic [FRAME_BITS-1:0]            rsp_frame_out,
    input logic [tlbr_pkg::SLOT_W-1:0]      rsp_slot
);
    a_no_word_in_reset: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result word valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
            && $stable(rsp_frame_out) && $stable(rsp_slot))
        else $error("stalled result word changed");

    a_miss_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_frame_out == '0)
        else $error("result without hit carries a frame");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high right after an accepted word");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result word appeared while the block was idle");
endmodule

bind tlb_fifo_lru_replacement tlbr_checker #(
    .FRAME_BITS (FRAME_BITS)
) u_tlbr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_hit       (rsp.hit),
    .rsp_frame_out (rsp.frame_out),
    .rsp_slot      (rsp.slot)
);

[sim/tlb_fifo_lru_replacement_tb.sv]
module tlb_fifo_lru_replacement_tb;

    import tlbr_pkg::*;

    localparam int MAX_ENTRIES = 16;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_BITS  = 20;
    localparam int PHASE_WORDS = 76;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 2000;

    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic POLICY_FIFO = 1'b0;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic                  op;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
    } tlb_word_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
        logic [SLOT_W-1:0]     slot;
    } tlb_result_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  op;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic                  given;
        tlb_result_t           want;
        reg_idx_t              cfg_reg;
        logic [EIU_W-1:0]      cfg_val;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    tlbr_req_if #(.PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)) req ();
    tlbr_rsp_if #(.FRAME_BITS(FRAME_BITS)) rsp ();

    tlb_fifo_lru_replacement #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    logic [PAGE_BITS-1:0]  tlb_page  [MAX_ENTRIES];
    logic [FRAME_BITS-1:0] tlb_frame [MAX_ENTRIES];
    logic [SLOT_W-1:0]     tlb_age   [MAX_ENTRIES];
    int                    tlb_used;
    logic                  cfg_lru;
    logic [EIU_W-1:0]      cfg_limit;

    tlb_result_t pending_translations [$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int stuck_cycles;

    dir_row_t directed_rows [27];
    logic     phase_lru   [9] = '{POLICY_FIFO, POLICY_LRU, POLICY_LRU, POLICY_FIFO, POLICY_LRU,
                                  POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU};
    int       phase_limit [9] = '{16, 16, 1, 1, 8, 0, 31, 5, 3};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [SLOT_W-1:0] age_raise(input logic [SLOT_W-1:0] a);
        return (a == SLOT_W'(MAX_ENTRIES - 1)) ? a : a + 1'b1;
    endfunction

    function automatic tlb_result_t tlb_translate(input tlb_word_t w);
        tlb_result_t       res;
        int                limit;
        int                found;
        int                victim;
        logic [SLOT_W-1:0] hit_age;
        res = '0;
        found = -1;
        if (w.op == OP_LOOKUP)
        begin
            for (int i = 0; i < tlb_used; i++)
                if (found < 0 && tlb_page[i] == w.page)
                    found = i;
            if (found >= 0)
            begin
                if (cfg_lru == POLICY_LRU)
                begin
                    hit_age = tlb_age[found];
                    for (int k = 0; k < tlb_used; k++)
                        if (k != found && tlb_age[k] < hit_age)
                            tlb_age[k] = age_raise(tlb_age[k]);
                    tlb_age[found] = '0;
                end
                res.hit       = 1'b1;
                res.frame_out = tlb_frame[found];
                res.slot      = SLOT_W'(found);
            end
            return res;
        end
        limit = (cfg_limit == 0) ? 1 : (cfg_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_limit);
        if (tlb_used < limit)
        begin
            victim = tlb_used;
            if (cfg_lru == POLICY_LRU)
            begin
                for (int i = 0; i < tlb_used; i++)
                    tlb_age[i] = age_raise(tlb_age[i]);
                tlb_age[victim] = '0;
            end
            else
            begin
                tlb_age[victim] = SLOT_W'(tlb_used);
            end
            tlb_used++;
        end
        else
        begin
            // FIFO evicts the oldest insertion, LRU the least recently used entry.
            victim = 0;
            for (int i = 1; i < tlb_used; i++)
                if (cfg_lru == POLICY_LRU ? tlb_age[i] > tlb_age[victim]
                                          : tlb_age[i] < tlb_age[victim])
                    victim = i;
            for (int i = 0; i < tlb_used; i++)
                if (i != victim)
                    tlb_age[i] = (cfg_lru == POLICY_LRU) ? age_raise(tlb_age[i]) :
                                 (tlb_age[i] == 0) ? tlb_age[i] : tlb_age[i] - 1'b1;
            tlb_age[victim] = (cfg_lru == POLICY_LRU) ? '0 : SLOT_W'(tlb_used - 1);
        end
        tlb_page[victim]  = w.page;
        tlb_frame[victim] = w.frame;
        res.slot = SLOT_W'(victim);
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_word(input tlb_word_t w, input logic given, input tlb_result_t want,
                             output tlb_result_t predicted);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= w.op;
        req.page  <= w.page;
        req.frame <= w.frame;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = tlb_translate(w);
        pending_translations.push_back(given ? want : predicted);
    endtask

    task automatic drain_block();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_translations.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_POLICY)
            cfg_lru = value[0];
        else
            cfg_limit = value[EIU_W-1:0];
        @(posedge clk);
    endtask

    // Mostly a lookup followed by a fill of the same page on a miss; the rest
    // are duplicate fills and words with fully random fields.
    task automatic random_phase(input int n_words, input logic with_hold);
        logic [PAGE_BITS-1:0] pool [12];
        tlb_word_t            w;
        tlb_result_t          r;
        int                   sent;
        int                   pick;
        logic                 hold_done;
        sent = 0;
        hold_done = 1'b0;
        foreach (pool[i])
            pool[i] = PAGE_BITS'($urandom);
        while (sent < n_words)
        begin
            if (with_hold && !hold_done && sent >= 12)
            begin
                hold_requests++;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            w.frame = FRAME_BITS'($urandom);
            if (pick < 75)
            begin
                w.op   = OP_LOOKUP;
                w.page = pool[$urandom_range(0, 11)];
                send_word(w, 1'b0, '0, r);
                sent++;
                if (!r.hit)
                begin
                    w.op    = OP_FILL;
                    w.frame = FRAME_BITS'($urandom);
                    send_word(w, 1'b0, '0, r);
                    sent++;
                end
            end
            else if (pick < 88)
            begin
                w.op   = OP_FILL;
                w.page = pool[$urandom_range(0, 11)];
                send_word(w, 1'b0, '0, r);
                sent++;
            end
            else
            begin
                w.op   = 1'($urandom_range(0, 1));
                w.page = PAGE_BITS'($urandom);
                send_word(w, 1'b0, '0, r);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : rsp_side
        tlb_result_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_translations.size() == 0)
                begin
                    flag_mismatch("result word with no lookup or fill outstanding");
                end
                else
                begin
                    want = pending_translations.pop_front();
                    if (rsp.hit !== want.hit)
                        flag_mismatch($sformatf("hit %b, expected %b", rsp.hit, want.hit));
                    if (rsp.frame_out !== want.frame_out)
                        flag_mismatch($sformatf("frame_out %h, expected %h",
                                                rsp.frame_out, want.frame_out));
                    if (rsp.slot !== want.slot)
                        flag_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        tlb_word_t   w;
        tlb_result_t r;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.op        = OP_LOOKUP;
        req.page      = '0;
        req.frame     = '0;
        rsp.ready     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tlb_used      = 0;
        cfg_lru       = POLICY_FIFO;
        cfg_limit     = EIU_RESET;
        mismatches    = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        stuck_cycles  = 0;
        send_idle_pct = 8;
        recv_idle_pct = 46;

        directed_rows = '{
            '{ROW_WORD, OP_LOOKUP, 20'hABCDE, 20'h00000, 1'b1, '{1'b0, 20'h00000, 4'd0},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h00000, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 4'd0},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'hFFFFF, 20'h00000, 1'b1, '{1'b0, 20'h00000, 4'd1},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h00000, 20'h12345, 1'b1, '{1'b1, 20'hFFFFF, 4'd0},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b1, 20'h00000, 4'd1},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h12345, 20'h54321, 1'b1, '{1'b0, 20'h00000, 4'd2},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h12345, 20'hAAAAA, 1'b1, '{1'b0, 20'h00000, 4'd3},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h12345, 20'h00000, 1'b1, '{1'b1, 20'h54321, 4'd2},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h00777, 20'h13579, 1'b1, '{1'b0, 20'h00000, 4'd0},
              REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 4'd0},
              REG_POLICY, 5'd0},
            '{ROW_CFG,  OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, '0, REG_POLICY, 5'(POLICY_LRU)},
            '{ROW_WORD, OP_LOOKUP, 20'hFFFFF, 20'h00000, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h55555, 20'h0F0F0, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h00777, 20'h00000, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h0AAAA, 20'hF0F0F, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_CFG,  OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, '0, REG_ENTRIES, 5'd2},
            '{ROW_WORD, OP_FILL,   20'h11111, 20'h22222, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h11111, 20'h00000, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_CFG,  OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, '0, REG_ENTRIES, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h22222, 20'h33333, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h22222, 20'h00000, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_CFG,  OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, '0, REG_ENTRIES, 5'd31},
            '{ROW_WORD, OP_FILL,   20'h33333, 20'h44444, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_FILL,   20'h44444, 20'h55555, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_CFG,  OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, '0, REG_POLICY, 5'(POLICY_FIFO)},
            '{ROW_WORD, OP_FILL,   20'h66666, 20'h77777, 1'b0, '0, REG_POLICY, 5'd0},
            '{ROW_WORD, OP_LOOKUP, 20'h33333, 20'h00000, 1'b0, '0, REG_POLICY, 5'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_block();
                apb_write(directed_rows[i].cfg_reg, CFG_DATA_W'(directed_rows[i].cfg_val));
            end
            else
            begin
                w.op    = directed_rows[i].op;
                w.page  = directed_rows[i].page;
                w.frame = directed_rows[i].frame;
                send_word(w, directed_rows[i].given, directed_rows[i].want, r);
            end
        end

        foreach (phase_lru[p])
        begin
            drain_block();
            apb_write(REG_POLICY, CFG_DATA_W'(phase_lru[p]));
            apb_write(REG_ENTRIES, CFG_DATA_W'(phase_limit[p]));
            if (p < 3)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 46;
            end
            else if (p < 6)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(PHASE_WORDS, p == 1);
        end

        drain_block();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
